FILE: hw/rtl/twt_pkg.sv
// Shared types, codes and reset values of the track window table.
package twt_pkg;

  // Table geometry default
  localparam int TABLE_DEPTH_DEF = 16;

  // Field widths
  localparam int ID_W    = 16;
  localparam int FRAME_W = 32;
  localparam int DUR_W   = 16;
  localparam int WIN_W   = 7;
  localparam int PEND_W  = 8;
  localparam int CFG_W   = 8;

  // Command codes
  localparam logic CMD_DETECT = 1'b0;
  localparam logic CMD_EOF    = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DETECT = 2'd0;
  localparam logic [1:0] KIND_FREED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // Match status codes
  localparam logic [1:0] ST_CONTINUED = 2'd0;
  localparam logic [1:0] ST_RESUMED   = 2'd1;
  localparam logic [1:0] ST_NEW       = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_MAX_PENDING = 2'd0;
  localparam logic [1:0] REG_POSE_LENGTH = 2'd1;
  localparam logic [1:0] REG_STEP_SIZE   = 2'd2;

  // Register reset values
  localparam logic [PEND_W-1:0] MAX_PENDING_RST = 8'd5;
  localparam logic [WIN_W-1:0]  POSE_LENGTH_RST = 7'd30;
  localparam logic [WIN_W-1:0]  STEP_SIZE_RST   = 7'd1;

  // Saturation limits
  localparam logic [WIN_W-1:0] WIN_MAX = '1;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  // One table entry as stored in the entry memory
  typedef struct packed {
    logic [ID_W-1:0]    track_id;
    logic [FRAME_W-1:0] last_frame;
    logic [FRAME_W-1:0] start_frame;
    logic [DUR_W-1:0]   duration;
    logic [WIN_W-1:0]   window_len;
  } entry_t;

  // Configuration registers
  typedef struct packed {
    logic [PEND_W-1:0] max_pending;
    logic [WIN_W-1:0]  pose_length;
    logic [WIN_W-1:0]  step_size;
  } cfg_t;

  // Evaluation of one entry by the update unit
  typedef struct packed {
    entry_t     hit_entry;
    logic [1:0] hit_status;
    logic       hit_ready;
    entry_t     walk_entry;
    logic       walk_write;
    logic       expired;
    logic       cur_ready;
  } eval_t;

endpackage

FILE: hw/rtl/track_window_table_top.sv
// Track window table: entry memory, walk sequencer and result register.
//
// Keeps up to TABLE_DEPTH tracked identities. A detection (cmd 0) is matched
// against every entry by a walk through the entry memory, one slot per cycle
// through its single read port, and puts its result on the result port. An
// end of frame (cmd 1) walks the table the same way, frees stale entries (one
// result each) and shrinks full windows, then gives a frame done result; its
// walk halts while the result consumer stalls a freed-entry result. The item
// port is ready again in the cycle the item's last result is loaded, so items
// never overlap. The configuration port is always ready; write it only while
// no item is in progress.
module track_window_table_top
  import twt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int SLOT_W = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              cmd,
  input  logic [ID_W-1:0]   track_id,
  // result channel
  output logic              res_valid,
  input  logic              res_ready,
  output logic [1:0]        kind,
  output logic [ID_W-1:0]   result_id,
  output logic [SLOT_W-1:0] slot,
  output logic [1:0]        match_status,
  output logic [DUR_W-1:0]  track_duration,
  output logic              window_ready,
  output logic              last_result,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DSCAN = 5'b00010,
    S_DDONE = 5'b00100,
    S_EWALK = 5'b01000,
    S_EDONE = 5'b10000
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   idx;
  logic [ID_W-1:0]    req_id;
  logic [TABLE_DEPTH-1:0] valid_bits;
  logic [FRAME_W-1:0] frame_counter;
  cfg_t               cfg;
  logic               hit_found;
  logic [SLOT_W-1:0]  hit_slot;
  entry_t             hit_entry;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;
  logic               rd_live;
  logic [SLOT_W-1:0]  rd_slot;
  entry_t             rd_entry;
  entry_t             mem [TABLE_DEPTH];

  logic               out_free;
  logic               scanning;
  logic               issue_ok;
  logic               chk_valid;
  logic               stall;
  logic               advance;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic               last_chk;
  logic               res_load;
  entry_t             alu_in;
  eval_t              alu_res;
  entry_t             new_entry;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  entry_t             wr_data;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  // Walk control
  assign out_free  = !res_valid || res_ready;
  assign scanning  = (state == S_DSCAN) || (state == S_EWALK);
  assign issue_ok  = (idx < IDX_W'(TABLE_DEPTH));
  assign rd_addr   = idx[SLOT_W-1:0];
  assign chk_valid = valid_bits[rd_slot];
  assign stall     = (state == S_EWALK) && rd_live && chk_valid && alu_res.expired
                     && !out_free;
  assign advance   = scanning && !stall;
  assign rd_en     = advance && issue_ok;
  assign last_chk  = rd_live && (rd_slot == SLOT_W'(TABLE_DEPTH - 1));

  // Load the result register on a freed entry or at the end of an item
  assign res_load  = (state == S_EWALK && rd_live && !stall && chk_valid && alu_res.expired)
                     || ((state == S_DDONE || state == S_EDONE) && out_free);

  // Share the update unit between the hit refresh and the walk
  assign alu_in = (state == S_DDONE) ? hit_entry : rd_entry;

  twt_alu u_alu (
    .ent   (alu_in),
    .frame (frame_counter),
    .cfg   (cfg),
    .res   (alu_res)
  );

  // Fresh entry on allocation
  always_comb begin
    new_entry             = '0;
    new_entry.track_id    = req_id;
    new_entry.last_frame  = frame_counter;
    new_entry.start_frame = frame_counter;
    new_entry.duration    = DUR_W'(1);
    new_entry.window_len  = WIN_W'(1);
  end

  // Select the single memory write of this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_slot;
    wr_data = alu_res.walk_entry;
    if (state == S_DDONE && out_free) begin
      if (hit_found) begin
        wr_en   = 1'b1;
        wr_addr = hit_slot;
        wr_data = alu_res.hit_entry;
      end else if (free_found) begin
        wr_en   = 1'b1;
        wr_addr = free_slot;
        wr_data = new_entry;
      end
    end else if (state == S_EWALK && rd_live && !stall && chk_valid
                 && !alu_res.expired && alu_res.walk_write) begin
      wr_en = 1'b1;
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
      rd_slot  <= rd_addr;
    end
  end

  // Sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      valid_bits    <= '0;
      frame_counter <= '0;
      cfg           <= '{MAX_PENDING_RST, POSE_LENGTH_RST, STEP_SIZE_RST};
      hit_found     <= 1'b0;
      free_found    <= 1'b0;
      rd_live       <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      // Take register writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_MAX_PENDING: cfg.max_pending <= cfg_data[PEND_W-1:0];
          REG_POSE_LENGTH: cfg.pose_length <= cfg_data[WIN_W-1:0];
          REG_STEP_SIZE:   cfg.step_size   <= cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end

      // Load a new result or drop the one just taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            req_id     <= track_id;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= (cmd == CMD_EOF) ? S_EWALK : S_DSCAN;
          end
        end

        S_DSCAN, S_EWALK: begin
          if (advance) begin
            rd_live <= issue_ok;
            if (issue_ok) begin
              idx <= idx + IDX_W'(1);
            end
          end
          // Check the slot read in the previous cycle
          if (state == S_DSCAN && rd_live && chk_valid) begin
            if (!hit_found && rd_entry.track_id == req_id) begin
              hit_found <= 1'b1;
              hit_slot  <= rd_slot;
              hit_entry <= rd_entry;
            end
          end else if (state == S_DSCAN && rd_live && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= rd_slot;
          end
          // Free a stale entry and report it
          if (state == S_EWALK && rd_live && !stall && chk_valid && alu_res.expired) begin
            valid_bits[rd_slot] <= 1'b0;
            kind           <= KIND_FREED;
            result_id      <= rd_entry.track_id;
            slot           <= rd_slot;
            match_status   <= ST_CONTINUED;
            track_duration <= rd_entry.duration;
            window_ready   <= alu_res.cur_ready;
            last_result    <= 1'b0;
          end
          if (last_chk && advance) begin
            state <= (state == S_DSCAN) ? S_DDONE : S_EDONE;
          end
        end

        S_DDONE: begin
          if (out_free) begin
            kind        <= KIND_DETECT;
            result_id   <= req_id;
            last_result <= 1'b1;
            if (hit_found) begin
              slot           <= hit_slot;
              match_status   <= alu_res.hit_status;
              track_duration <= alu_res.hit_entry.duration;
              window_ready   <= alu_res.hit_ready;
            end else if (free_found) begin
              valid_bits[free_slot] <= 1'b1;
              slot           <= free_slot;
              match_status   <= ST_NEW;
              track_duration <= DUR_W'(1);
              window_ready   <= (WIN_W'(1) >= cfg.pose_length);
            end else begin
              slot           <= '0;
              match_status   <= ST_FULL;
              track_duration <= '0;
              window_ready   <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        S_EDONE: begin
          if (out_free) begin
            kind           <= KIND_DONE;
            result_id      <= '0;
            slot           <= '0;
            match_status   <= ST_CONTINUED;
            track_duration <= '0;
            window_ready   <= 1'b0;
            last_result    <= 1'b1;
            frame_counter  <= frame_counter + FRAME_W'(1);
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/twt_alu.sv
// Shared entry update unit: refresh on a hit, expiry and window shrink on a walk.
module twt_alu
  import twt_pkg::*;
(
  input  entry_t             ent,
  input  logic [FRAME_W-1:0] frame,
  input  cfg_t               cfg,
  output eval_t              res
);

  logic [FRAME_W:0]   expire_lim;
  logic [WIN_W-1:0]   drop;
  logic               same_frame;

  // Compare the entry age against the pending limit without wrap
  assign expire_lim = {1'b0, ent.last_frame} + {{(FRAME_W + 1 - PEND_W){1'b0}}, cfg.max_pending};
  assign same_frame = (ent.last_frame == frame);
  assign drop       = (cfg.step_size > ent.window_len) ? ent.window_len : cfg.step_size;

  always_comb begin
    res = '0;

    // Refresh a matched entry
    res.hit_entry            = ent;
    res.hit_entry.last_frame = frame;
    res.hit_entry.duration   = (ent.duration == DUR_MAX) ? ent.duration
                                                         : ent.duration + DUR_W'(1);
    res.hit_entry.window_len = (ent.window_len == WIN_MAX) ? ent.window_len
                                                           : ent.window_len + WIN_W'(1);
    res.hit_status = (same_frame || (ent.last_frame + FRAME_W'(1) == frame)) ? ST_CONTINUED
                                                                             : ST_RESUMED;
    res.hit_ready  = (res.hit_entry.window_len >= cfg.pose_length);

    // Age out or shrink during the end-of-frame walk
    res.expired    = (expire_lim < {1'b0, frame});
    res.cur_ready  = (ent.window_len >= cfg.pose_length);
    res.walk_write = same_frame && res.cur_ready;
    res.walk_entry             = ent;
    res.walk_entry.window_len  = ent.window_len - drop;
    res.walk_entry.start_frame = ent.start_frame + {{(FRAME_W - WIN_W){1'b0}}, drop};
  end

endmodule

FILE: hw/rtl/twt_checker.sv
// Port-level checker of the track window table and its bind.
module twt_checker
  import twt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int SLOT_W = $clog2(TABLE_DEPTH)
) (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              cmd,
  input logic [ID_W-1:0]   track_id,
  input logic              res_valid,
  input logic              res_ready,
  input logic [1:0]        kind,
  input logic [ID_W-1:0]   result_id,
  input logic [SLOT_W-1:0] slot,
  input logic [1:0]        match_status,
  input logic [DUR_W-1:0]  track_duration,
  input logic              window_ready,
  input logic              last_result,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [1:0]        cfg_index,
  input logic [CFG_W-1:0]  cfg_data
);

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending after reset");

  // One item at a time: the item port closes after a transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item port still ready after a transaction");

  // Freed entries never close an item, frame done always does
  a_freed_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_FREED |-> !last_result && match_status == ST_CONTINUED)
    else $error("freed entry result marked last or with a status");

  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_DONE |-> last_result && result_id == '0 && track_duration == '0)
    else $error("malformed frame done result");

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(result_id)
                                && $stable(slot) && $stable(last_result))
    else $error("stalled result changed");

endmodule

bind track_window_table_top twt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_twt_checker (.*);
